### src/multilevel_feedback_scheduler_unit_defines.svh
// Assertion helpers for the feedback scheduler checker.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_UNIT_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define MFS_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define MFS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/mfs_pkg.sv
package mfs_pkg;

   // Field widths
   localparam int SLOT_W      = 5;
   localparam int LEVEL_W     = 2;
   localparam int BURST_W     = 32;
   localparam int QUANTUM_W   = 30;
   // Largest level shift applied to the base quantum
   localparam int MAX_SHIFT   = 3;
   localparam int SHIFTED_W   = QUANTUM_W + MAX_SHIFT;

   // Ready queue geometry, per level
   localparam int QUEUE_DEPTH = 16;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Defaults for the top-level parameters
   localparam int DEF_PROCESS_SLOTS = 16;
   localparam int DEF_NUM_LEVELS    = 3;

   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 30'd10000000;

   // Commands
   localparam logic [1:0] CMD_ADMIT    = 2'd0;
   localparam logic [1:0] CMD_DISPATCH = 2'd1;
   localparam logic [1:0] CMD_REPORT   = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic [SLOT_W-1:0]  pid;
      logic [BURST_W-1:0] burst;
      logic               finished;
   } mfs_req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  result_pid;
      logic [LEVEL_W-1:0] result_level;
      logic [1:0]         status;
      logic               released;
   } mfs_rsp_type;

   // Update to the slot table, one slot per item
   typedef struct packed {
      logic               set_busy;
      logic               clr_busy;
      logic               wr_level;
      logic [SLOT_W-1:0]  slot;
      logic [LEVEL_W-1:0] level;
   } mfs_slot_cmd_type;

   // Slot table lookups
   typedef struct packed {
      logic               free_found;
      logic [SLOT_W-1:0]  free_slot;
      logic               query_busy;
      logic [LEVEL_W-1:0] query_level;
   } mfs_slot_stat_type;

   // Push and pop on the ready queues
   typedef struct packed {
      logic               push;
      logic [LEVEL_W-1:0] push_level;
      logic [SLOT_W-1:0]  push_slot;
      logic               pop;
      logic [LEVEL_W-1:0] pop_level;
   } mfs_queue_cmd_type;

endpackage

### src/multilevel_feedback_scheduler_unit.sv
// Multilevel feedback scheduler.
// Items enter on the req_ channel (valid/ready) and carry a command:
// admit a new process, dispatch the next ready one, or report how long a
// process ran. Every item gives exactly one result item on the rsp_
// channel (valid/ready) with the slot, its queue level, a status and a
// released flag.
// An accepted item waits in the input register; the decision and all
// slot-table and queue updates are made from it in the cycle that it
// moves on, and the result is held in the result register. One item can
// be accepted every cycle while results are taken.
// A stalled rsp_ready holds the result register; the input register still
// takes one more item, then req_ready drops until the result is taken.
// Synchronous reset empties the input and result registers, frees every
// slot, empties every ready queue and sets base_quantum to 10000000.
// The csr_ port writes base_quantum; write it while idle.
module multilevel_feedback_scheduler_unit import mfs_pkg::*; #(
   parameter int PROCESS_SLOTS = DEF_PROCESS_SLOTS,
   parameter int NUM_LEVELS    = DEF_NUM_LEVELS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mfs_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mfs_rsp_type          rsp_data,
   input  logic                 csr_wr_en,
   input  logic [QUANTUM_W-1:0] csr_wr_data
);

   logic                            in_valid_ff;
   logic                            in_valid_in;
   mfs_req_type                     in_data_ff;
   logic                            out_valid_ff;
   logic                            out_valid_in;
   mfs_rsp_type                     out_data_ff;
   mfs_rsp_type                     out_data_in;
   logic [QUANTUM_W-1:0]            base_ff;
   logic                            advance;
   mfs_slot_cmd_type                slot_cmd;
   mfs_slot_stat_type               slot_stat;
   mfs_queue_cmd_type               queue_cmd;
   logic [NUM_LEVELS-1:0]           q_nonempty;
   logic [NUM_LEVELS-1:0][SLOT_W-1:0] q_head;
   logic                            disp_found;
   logic [LEVEL_W-1:0]              disp_level;
   logic [SLOT_W-1:0]               disp_slot;
   logic [SHIFTED_W-1:0]            quantum;
   logic                            demote;
   logic [LEVEL_W-1:0]              next_level;

   // Handshake: move the held item on when the result register frees up
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         base_ff      <= QUANTUM_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) base_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_data_ff <= req_data;
      if (advance) out_data_ff <= out_data_in;
   end

   mfs_slot_table #(
      .PROCESS_SLOTS (PROCESS_SLOTS)
   ) u_slots (
      .clock      (clock),
      .reset      (reset),
      .cmd        (slot_cmd),
      .query_slot (in_data_ff.pid),
      .stat       (slot_stat)
   );

   mfs_ready_queues #(
      .NUM_LEVELS (NUM_LEVELS)
   ) u_queues (
      .clock     (clock),
      .reset     (reset),
      .cmd       (queue_cmd),
      .nonempty  (q_nonempty),
      .head_slot (q_head)
   );

   // Pick the highest-priority non-empty level and its head slot
   always_comb begin
      disp_found = 1'b0;
      disp_level = '0;
      disp_slot  = '0;
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
         if (q_nonempty[l]) begin
            disp_found = 1'b1;
            disp_level = LEVEL_W'(l);
         end
      end
      for (int l = 0; l < NUM_LEVELS; l++) begin
         if (disp_level == LEVEL_W'(l)) disp_slot = q_head[l];
      end
   end

   // Compare the burst with the level's quantum and choose the new level
   always_comb begin
      quantum = SHIFTED_W'(base_ff) << slot_stat.query_level;
      demote  = SHIFTED_W'(in_data_ff.burst) >= quantum;
      if (!demote) begin
         next_level = '0;
      end else if (slot_stat.query_level == LEVEL_W'(NUM_LEVELS - 1)) begin
         next_level = slot_stat.query_level;
      end else begin
         next_level = LEVEL_W'(slot_stat.query_level + 1'b1);
      end
   end

   // Decide the item: table updates, queue operations and the result
   always_comb begin
      slot_cmd    = '0;
      queue_cmd   = '0;
      out_data_in = '0;
      if (advance) begin
         case (in_data_ff.command)
            CMD_ADMIT: begin
               if (slot_stat.free_found) begin
                  slot_cmd.set_busy = 1'b1;
                  slot_cmd.wr_level = 1'b1;
                  slot_cmd.slot     = slot_stat.free_slot;
                  queue_cmd.push      = 1'b1;
                  queue_cmd.push_slot = slot_stat.free_slot;
                  out_data_in.result_pid = slot_stat.free_slot;
               end else begin
                  out_data_in.status = ST_FULL;
               end
            end
            CMD_DISPATCH: begin
               if (disp_found) begin
                  queue_cmd.pop       = 1'b1;
                  queue_cmd.pop_level = disp_level;
                  out_data_in.result_pid   = disp_slot;
                  out_data_in.result_level = disp_level;
               end else begin
                  out_data_in.status = ST_EMPTY;
               end
            end
            CMD_REPORT: begin
               // Out-of-range or idle slots read as not busy: ignore them
               if (slot_stat.query_busy) begin
                  slot_cmd.slot = in_data_ff.pid;
                  out_data_in.result_pid = in_data_ff.pid;
                  if (in_data_ff.finished) begin
                     slot_cmd.clr_busy = 1'b1;
                     out_data_in.result_level = slot_stat.query_level;
                     out_data_in.released     = 1'b1;
                  end else begin
                     slot_cmd.wr_level    = 1'b1;
                     slot_cmd.level       = next_level;
                     queue_cmd.push       = 1'b1;
                     queue_cmd.push_level = next_level;
                     queue_cmd.push_slot  = in_data_ff.pid;
                     out_data_in.result_level = next_level;
                  end
               end
            end
            default: begin
               out_data_in = '0;
            end
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

### src/mfs_slot_table.sv
module mfs_slot_table import mfs_pkg::*; #(
   parameter int PROCESS_SLOTS = DEF_PROCESS_SLOTS
) (
   input  logic              clock,
   input  logic              reset,
   input  mfs_slot_cmd_type  cmd,
   input  logic [SLOT_W-1:0] query_slot,
   output mfs_slot_stat_type stat
);

   logic [PROCESS_SLOTS-1:0] busy_ff;
   logic [PROCESS_SLOTS-1:0] busy_in;
   logic [LEVEL_W-1:0]       level_ff [PROCESS_SLOTS];

   // Set or clear the busy bit of the addressed slot
   always_comb begin
      busy_in = busy_ff;
      for (int i = 0; i < PROCESS_SLOTS; i++) begin
         if (cmd.slot == SLOT_W'(i)) begin
            if (cmd.set_busy) busy_in[i] = 1'b1;
            if (cmd.clr_busy) busy_in[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // Write the level of the addressed slot; read only once the slot is busy
   always_ff @(posedge clock) begin
      for (int i = 0; i < PROCESS_SLOTS; i++) begin
         if (cmd.wr_level && cmd.slot == SLOT_W'(i)) begin
            level_ff[i] <= cmd.level;
         end
      end
   end

   // Find the lowest free slot and look up the queried slot
   always_comb begin
      stat = '0;
      for (int i = PROCESS_SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            stat.free_found = 1'b1;
            stat.free_slot  = SLOT_W'(i);
         end
      end
      for (int i = 0; i < PROCESS_SLOTS; i++) begin
         if (query_slot == SLOT_W'(i)) begin
            stat.query_busy  = busy_ff[i];
            stat.query_level = level_ff[i];
         end
      end
   end

endmodule

### src/mfs_ready_queues.sv
module mfs_ready_queues import mfs_pkg::*; #(
   parameter int NUM_LEVELS = DEF_NUM_LEVELS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mfs_queue_cmd_type                  cmd,
   output logic [NUM_LEVELS-1:0]              nonempty,
   output logic [NUM_LEVELS-1:0][SLOT_W-1:0]  head_slot
);

   for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_level
      logic [SLOT_W-1:0] entry_ff [QUEUE_DEPTH];
      logic [SLOT_W-1:0] head_slot_ff;
      logic [QPTR_W-1:0] head_ff;
      logic [QPTR_W-1:0] head_in;
      logic [QPTR_W-1:0] tail_ff;
      logic [QPTR_W-1:0] tail_in;
      logic [QCNT_W-1:0] count_ff;
      logic [QCNT_W-1:0] count_in;
      logic              push_hit;
      logic              pop_hit;

      // Decode push and pop for this level; drop a push to a full queue
      always_comb begin
         push_hit = cmd.push && cmd.push_level == LEVEL_W'(l)
                    && count_ff != QCNT_W'(QUEUE_DEPTH);
         pop_hit  = cmd.pop && cmd.pop_level == LEVEL_W'(l)
                    && count_ff != '0;
         head_in  = pop_hit  ? QPTR_W'(head_ff + 1'b1) : head_ff;
         tail_in  = push_hit ? QPTR_W'(tail_ff + 1'b1) : tail_ff;
         count_in = count_ff;
         if (push_hit) count_in = QCNT_W'(count_ff + 1'b1);
         if (pop_hit)  count_in = QCNT_W'(count_ff - 1'b1);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            head_ff  <= '0;
            tail_ff  <= '0;
            count_ff <= '0;
         end else begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
      end

      // Store pushed slots at the tail
      always_ff @(posedge clock) begin
         if (push_hit) begin
            entry_ff[tail_ff] <= cmd.push_slot;
         end
      end

      // Read the next head; bypass a push into an empty queue
      always_ff @(posedge clock) begin
         if (push_hit && count_ff == '0) begin
            head_slot_ff <= cmd.push_slot;
         end else begin
            head_slot_ff <= entry_ff[head_in];
         end
      end

      // Show this level's head and occupancy
      assign nonempty[l]  = count_ff != '0;
      assign head_slot[l] = head_slot_ff;
   end

endmodule

### src/mfs_checker.sv
`include "multilevel_feedback_scheduler_unit_defines.svh"

module mfs_checker import mfs_pkg::*; #(
   parameter int PROCESS_SLOTS = DEF_PROCESS_SLOTS,
   parameter int NUM_LEVELS    = DEF_NUM_LEVELS
) (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input mfs_rsp_type rsp_data
);

   // Hold a stalled result
   `MFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   // Take an item whenever the result register is empty
   `MFS_ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "input stalled with empty output")

   // Error results carry no slot, level or release
   `MFS_ASSERT_IMPLY(a_err_zero, clock, reset, rsp_valid && rsp_data.status != ST_OK, rsp_data.result_pid == '0 && rsp_data.result_level == '0 && !rsp_data.released, "error result with payload")

   // Results name only real slots and levels
   `MFS_ASSERT_IMPLY(a_range, clock, reset, rsp_valid, int'(rsp_data.result_pid) < PROCESS_SLOTS && int'(rsp_data.result_level) < NUM_LEVELS, "slot or level out of range")

endmodule

bind multilevel_feedback_scheduler_unit mfs_checker #(
   .PROCESS_SLOTS (PROCESS_SLOTS),
   .NUM_LEVELS    (NUM_LEVELS)
) u_mfs_checker (.*);
